FILE: src/qau_pkg.sv
// shared constants, codes and helper functions of the quaternion arithmetic unit
package qau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int EXP_BITS  = 16;
  localparam int ACC_BITS  = 2 * WORD_BITS + 2;
  localparam int NUM_BITS  = 2 * WORD_BITS;
  localparam int DEN_BITS  = 2 * WORD_BITS + 1;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_CONJ  = 3'd3;
  localparam logic [2:0] OP_NEG   = 3'd4;
  localparam logic [2:0] OP_INV   = 3'd5;
  localparam logic [2:0] OP_EQUAL = 3'd6;
  localparam logic [2:0] OP_POWER = 3'd7;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // operand b index for hamilton product term (row c, term k)
  function automatic logic [1:0] bsel(input logic [1:0] c, input logic [1:0] k);
    bsel = c ^ k;
  endfunction

  // term is subtracted
  function automatic logic bneg(input logic [1:0] c, input logic [1:0] k);
    logic r;
    r = 1'b0;
    case ({c, k})
      4'b0001, 4'b0010, 4'b0011, 4'b0111, 4'b1001, 4'b1110: r = 1'b1;
      default: r = 1'b0;
    endcase
    bneg = r;
  endfunction

  // returns {overflow, value}
  function automatic logic [WORD_BITS:0] sat33(input logic signed [WORD_BITS:0] v);
    logic [WORD_BITS:0] r;
    if (v[WORD_BITS] != v[WORD_BITS-1]) begin
      r = {1'b1, v[WORD_BITS], {(WORD_BITS-1){~v[WORD_BITS]}}};
    end else begin
      r = {1'b0, v[WORD_BITS-1:0]};
    end
    sat33 = r;
  endfunction

  // returns {overflow, value}
  function automatic logic [WORD_BITS:0] satacc(
    input logic signed [ACC_BITS-FRAC_BITS-1:0] v
  );
    logic [WORD_BITS:0] r;
    logic hi_ok;
    hi_ok = (v[ACC_BITS-FRAC_BITS-1:WORD_BITS-1] == '0) ||
            (v[ACC_BITS-FRAC_BITS-1:WORD_BITS-1] == '1);
    if (!hi_ok) begin
      r = {1'b1, v[ACC_BITS-FRAC_BITS-1], {(WORD_BITS-1){~v[ACC_BITS-FRAC_BITS-1]}}};
    end else begin
      r = {1'b0, v[WORD_BITS-1:0]};
    end
    satacc = r;
  endfunction

endpackage

FILE: src/qau_div.sv
// restoring unsigned divider, one quotient bit per cycle
module qau_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [qau_pkg::NUM_BITS-1:0]   num,
  input  logic [qau_pkg::DEN_BITS-1:0]   den,
  output logic                           done,
  output logic [qau_pkg::NUM_BITS-1:0]   quo,
  output logic [qau_pkg::DEN_BITS:0]     rem
);

  logic [qau_pkg::DEN_BITS:0] trial;
  logic [6:0]                 cnt;
  logic                       busy;
  logic                       ge;

  assign trial = {rem[qau_pkg::DEN_BITS-1:0], quo[qau_pkg::NUM_BITS-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= num;
      end else if (busy) begin
        rem <= ge ? trial - {1'b0, den} : trial;
        quo <= {quo[qau_pkg::NUM_BITS-2:0], ge};
        cnt <= cnt + 7'd1;
        if (cnt == 7'(qau_pkg::NUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/quaternion_arithmetic_unit.sv
// quaternion arithmetic unit top level: sequencer, shared multiplier, divider
// add, sub, conj, neg, equal: result registered and shown the cycle after the input is taken
// product: every Hamilton product term on the shared 32x32 multiplier, then a drain
// inverse: norm (sum of squares) on the multiplier, then one rounded division per component
// power: up to 29 square or multiply steps, after an inverse of the base for a negative exponent
// one item at a time; rst clears the sequencer and output valid synchronously
module quaternion_arithmetic_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [271:0] s_tdata,  // a_re, a_i, a_j, a_k, b_re, b_i, b_j, b_k, exponent
  input  logic [2:0]   s_tuser,  // opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,  // res_re, res_i, res_j, res_k
  output logic [2:0]   m_tuser   // is_equal, status
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_NORM   = 4'd2;
  localparam logic [3:0] S_DSTART = 4'd3;
  localparam logic [3:0] S_DWAIT  = 4'd4;
  localparam logic [3:0] S_IFIN   = 4'd5;
  localparam logic [3:0] S_POW    = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;

  localparam int W = qau_pkg::WORD_BITS;
  localparam int A = qau_pkg::ACC_BITS;

  logic [3:0] state;
  logic [2:0] op;
  logic       ovf;
  logic       dest_base;
  logic [qau_pkg::EXP_BITS:0] d;
  logic [4:0] cnt;
  logic [1:0] dc;

  logic signed [W-1:0] xs [4];
  logic signed [W-1:0] ys [4];
  logic signed [W-1:0] base [4];
  logic signed [W-1:0] r [4];
  logic signed [W-1:0] t [4];
  logic signed [W-1:0] res [4];
  logic       out_eq;
  logic [1:0] out_st;

  logic signed [2*W-1:0] p;
  logic       p_v, p_neg;
  logic [1:0] p_k, p_c;
  logic signed [A-1:0] acc, acc_base, acc_new;
  logic [qau_pkg::DEN_BITS-1:0] norm;
  logic [W:0] sat_t;

  logic [1:0] ck, kk;
  logic [4:0] limit;
  logic       in_norm;

  logic                          div_start, div_done;
  logic [qau_pkg::NUM_BITS-1:0]  div_q;
  logic [qau_pkg::DEN_BITS:0]    div_rem;
  logic [W-1:0]                  mag;
  logic [qau_pkg::NUM_BITS:0]    qr;
  logic                          ineg, rup;
  logic [W:0]                    inv_c;

  logic signed [W-1:0] ia [4];
  logic signed [W-1:0] ib [4];
  logic signed [qau_pkg::EXP_BITS-1:0] iexp;
  logic [W:0] dsum [4];
  logic [W:0] dneg [4];
  logic       dovf;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ia[i] = s_tdata[i*W +: W];
      ib[i] = s_tdata[(i+4)*W +: W];
    end
    iexp = s_tdata[8*W +: qau_pkg::EXP_BITS];
  end

  always_comb begin
    dovf = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (s_tuser == qau_pkg::OP_SUB) begin
        dsum[i] = qau_pkg::sat33({ia[i][W-1], ia[i]} - {ib[i][W-1], ib[i]});
      end else begin
        dsum[i] = qau_pkg::sat33({ia[i][W-1], ia[i]} + {ib[i][W-1], ib[i]});
      end
      dneg[i] = qau_pkg::sat33((W+1)'(0) - {ia[i][W-1], ia[i]});
      if (s_tuser == qau_pkg::OP_ADD || s_tuser == qau_pkg::OP_SUB) begin
        dovf = dovf | dsum[i][W];
      end else if (i != 0 || s_tuser == qau_pkg::OP_NEG) begin
        dovf = dovf | dneg[i][W];
      end
    end
  end

  assign ck      = cnt[3:2];
  assign kk      = cnt[1:0];
  assign in_norm = (state == S_NORM);
  assign limit   = in_norm ? 5'd4 : 5'd16;

  assign acc_base = (p_k == 2'd0) ? (in_norm ? A'(0) : A'(1 << (qau_pkg::FRAC_BITS - 1)))
                                  : acc;
  assign acc_new  = p_neg ? acc_base - A'(p) : acc_base + A'(p);
  assign sat_t    = qau_pkg::satacc(acc_new[A-1:qau_pkg::FRAC_BITS]);

  assign mag   = xs[dc][W-1] ? W'(0) - xs[dc] : xs[dc];
  assign rup   = {div_rem[qau_pkg::DEN_BITS-1:0], 1'b0} >= {1'b0, norm};
  assign qr    = {1'b0, div_q} + (qau_pkg::NUM_BITS+1)'(rup);
  assign ineg  = (dc == 2'd0) ? xs[dc][W-1] : (!xs[dc][W-1] && xs[dc] != '0);

  always_comb begin
    if (ineg) begin
      if (qr > (qau_pkg::NUM_BITS+1)'(1) << (W-1)) begin
        inv_c = {1'b1, 1'b1, {(W-1){1'b0}}};
      end else begin
        inv_c = {1'b0, W'(0) - qr[W-1:0]};
      end
    end else begin
      if (qr > ((qau_pkg::NUM_BITS+1)'(1) << (W-1)) - 1) begin
        inv_c = {1'b1, 1'b0, {(W-1){1'b1}}};
      end else begin
        inv_c = {1'b0, qr[W-1:0]};
      end
    end
  end

  assign div_start = (state == S_DSTART);

  qau_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({mag, {W{1'b0}}}),
    .den   (norm),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if ((state == S_MUL || state == S_NORM) && cnt < limit) begin
      p     <= in_norm ? xs[kk] * xs[kk] : xs[kk] * ys[qau_pkg::bsel(ck, kk)];
      p_neg <= in_norm ? 1'b0 : qau_pkg::bneg(ck, kk);
      p_k   <= kk;
      p_c   <= ck;
    end
    if (p_v) begin
      acc <= acc_new;
      if (p_k == 2'd3 && !in_norm) t[p_c] <= sat_t[W-1:0];
      if (p_k == 2'd3 && in_norm) norm <= acc_new[qau_pkg::DEN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      p_v      <= 1'b0;
      cnt      <= '0;
    end else begin
      p_v <= (state == S_MUL || state == S_NORM) && cnt < limit;
      if ((state == S_MUL || state == S_NORM) && cnt < limit) cnt <= cnt + 5'd1;
      if (p_v && p_k == 2'd3 && !in_norm) ovf <= ovf | sat_t[W];
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op     <= s_tuser;
            ovf    <= 1'b0;
            cnt    <= '0;
            dc     <= '0;
            out_eq <= 1'b0;
            for (int i = 0; i < 4; i++) begin
              xs[i] <= ia[i];
              ys[i] <= ib[i];
              base[i] <= ia[i];
              r[i] <= (i == 0) ? W'(1 << qau_pkg::FRAC_BITS) : '0;
            end
            d <= iexp[qau_pkg::EXP_BITS-1] ? (qau_pkg::EXP_BITS+1)'(0) - {1'b1, iexp}
                                           : {1'b0, iexp};
            case (s_tuser)
              qau_pkg::OP_ADD, qau_pkg::OP_SUB, qau_pkg::OP_CONJ, qau_pkg::OP_NEG: begin
                for (int i = 0; i < 4; i++) begin
                  if (s_tuser == qau_pkg::OP_ADD || s_tuser == qau_pkg::OP_SUB)
                    res[i] <= dsum[i][W-1:0];
                  else if (i == 0 && s_tuser == qau_pkg::OP_CONJ) res[i] <= ia[i];
                  else res[i] <= dneg[i][W-1:0];
                end
                out_st   <= dovf ? qau_pkg::ST_OVF : qau_pkg::ST_OK;
                m_tvalid <= 1'b1;
                state    <= S_OUT;
              end
              qau_pkg::OP_EQUAL: begin
                for (int i = 0; i < 4; i++) res[i] <= '0;
                out_eq   <= (ia[0] == ib[0]) && (ia[1] == ib[1]) &&
                            (ia[2] == ib[2]) && (ia[3] == ib[3]);
                out_st   <= qau_pkg::ST_OK;
                m_tvalid <= 1'b1;
                state    <= S_OUT;
              end
              qau_pkg::OP_MUL: begin
                dest_base <= 1'b0;
                state     <= S_MUL;
              end
              qau_pkg::OP_INV: state <= S_NORM;
              default: state <= iexp[qau_pkg::EXP_BITS-1] ? S_NORM : S_POW;
            endcase
          end
        end
        S_MUL: begin
          if (cnt == limit && !p_v) begin
            for (int i = 0; i < 4; i++) begin
              if (dest_base) base[i] <= t[i];
              else r[i] <= t[i];
            end
            if (op == qau_pkg::OP_MUL) begin
              for (int i = 0; i < 4; i++) res[i] <= t[i];
              out_st   <= (ovf | (p_v & sat_t[W])) ? qau_pkg::ST_OVF : qau_pkg::ST_OK;
              m_tvalid <= 1'b1;
              state    <= S_OUT;
            end else begin
              state <= S_POW;
            end
          end
        end
        S_NORM: begin
          if (cnt == limit && !p_v) begin
            if (norm == '0) begin
              for (int i = 0; i < 4; i++) res[i] <= '0;
              out_st   <= qau_pkg::ST_DZ;
              m_tvalid <= 1'b1;
              state    <= S_OUT;
            end else begin
              state <= S_DSTART;
            end
          end
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            base[dc] <= inv_c[W-1:0];
            ovf      <= ovf | inv_c[W];
            dc       <= dc + 2'd1;
            state    <= (dc == 2'd3) ? S_IFIN : S_DSTART;
          end
        end
        S_IFIN: begin
          if (op == qau_pkg::OP_INV) begin
            for (int i = 0; i < 4; i++) res[i] <= base[i];
            out_st   <= ovf ? qau_pkg::ST_OVF : qau_pkg::ST_OK;
            m_tvalid <= 1'b1;
            state    <= S_OUT;
          end else begin
            state <= S_POW;
          end
        end
        S_POW: begin
          cnt <= '0;
          if (d == '0) begin
            for (int i = 0; i < 4; i++) res[i] <= r[i];
            out_st   <= ovf ? qau_pkg::ST_OVF : qau_pkg::ST_OK;
            m_tvalid <= 1'b1;
            state    <= S_OUT;
          end else if (d[0]) begin
            for (int i = 0; i < 4; i++) begin
              xs[i] <= r[i];
              ys[i] <= base[i];
            end
            dest_base <= 1'b0;
            d         <= d - 1'b1;
            state     <= S_MUL;
          end else begin
            for (int i = 0; i < 4; i++) begin
              xs[i] <= base[i];
              ys[i] <= base[i];
            end
            dest_base <= 1'b1;
            d         <= d >> 1;
            state     <= S_MUL;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {res[3], res[2], res[1], res[0]};
  assign m_tuser  = {out_st, out_eq};

endmodule

FILE: src/qau_checker.sv
// port level checks of the quaternion arithmetic unit, bound to the top level
module qau_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic [2:0]   m_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result valid dropped before transfer");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while result pending");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[2:1] != 2'd3)
    else $error("undefined status code");

  a_eq_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[2:1] == qau_pkg::ST_OK && m_tdata == '0)
    else $error("equal result with nonzero data or status");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
